// ----- sv/mi4_pkg.sv -----
package mi4_pkg;

   localparam int ELEMENT_WIDTH = 16;
   localparam int FRACTION_BITS = 12;

   // n-th surviving index (0..2) once index x is removed from 0..3
   function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] n);
      logic [1:0] r;
      r = (n < x) ? n : n + 2'd1;
      return r;
   endfunction

   // column picked in row t of the 3x3 minor by expansion term e (0..5)
   function automatic logic [1:0] perm_col(input logic [2:0] e, input logic [1:0] t);
      logic [5:0] p;
      case (e)
         3'd0: p = {2'd2, 2'd1, 2'd0};
         3'd1: p = {2'd1, 2'd2, 2'd0};
         3'd2: p = {2'd2, 2'd0, 2'd1};
         3'd3: p = {2'd0, 2'd2, 2'd1};
         3'd4: p = {2'd1, 2'd0, 2'd2};
         default: p = {2'd0, 2'd1, 2'd2};
      endcase
      case (t)
         2'd0: return p[1:0];
         2'd1: return p[3:2];
         default: return p[5:4];
      endcase
   endfunction

   // odd permutations carry a minus sign
   function automatic logic term_neg(input logic [2:0] e);
      return (e == 3'd1) || (e == 3'd2) || (e == 3'd5);
   endfunction

endpackage

// ----- sv/mi4_if.sv -----
interface mi4_req_if #(parameter int W = mi4_pkg::ELEMENT_WIDTH);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] element;
   modport source (output valid, output element, input ready);
   modport sink (input valid, input element, output ready);
endinterface

interface mi4_rsp_if #(parameter int W = mi4_pkg::ELEMENT_WIDTH);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] value;
   logic [3:0]          position;
   logic                singular;
   logic                clipped;
   logic                last;
   modport source (output valid, output value, output position, output singular,
                   output clipped, output last, input ready);
   modport sink (input valid, input value, input position, input singular,
                 input clipped, input last, output ready);
endinterface

// ----- sv/matrix_inverse_4x4.sv -----
// 4x4 matrix inverse by adjugate and cofactors, signed fixed point.
// req_ch carries one matrix element per transfer, row-major; the sixteenth
// element closes a matrix and hands it to a two-deep matrix queue, so
// elements of the next matrices load while the current one is worked on.
// rsp_ch returns sixteen inverse elements per matrix, row-major, with their
// position, a singular flag (zero determinant, value 0), a clipped flag on
// saturation and last on the sixteenth.
// req_ch is always ready for elements 1..15; the sixteenth waits for room in
// the queue. The back end uses one shift-add multiplier and one restoring
// divider (3*ELEMENT_WIDTH + 2*FRACTION_BITS quotient bits, one bit a cycle).
// Per matrix: 16 cofactors of 6 terms each, two products per term, then the
// determinant from 4 row-0 products, then 16 quotients for the results.
// Reset clears the load count, the queue and the sequencer; stored data is
// not cleared. When rsp_ch stalls, the result register holds and the back
// end waits; req_ch keeps loading, and with the queue full only the closing element waits.
module matrix_inverse_4x4 #(
   parameter int ELEMENT_WIDTH = mi4_pkg::ELEMENT_WIDTH,
   parameter int FRACTION_BITS = mi4_pkg::FRACTION_BITS
) (
   input  logic      clock,
   input  logic      reset,
   mi4_req_if.sink   req_ch,
   mi4_rsp_if.source rsp_ch
);
   localparam int MW = 16 * ELEMENT_WIDTH;

   logic          q_full, q_push, q_valid, q_pop;
   logic [MW-1:0] front_matrix, back_matrix;

   mi4_front #(.W(ELEMENT_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_element (req_ch.element),
      .in_ready   (req_ch.ready),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_matrix   (front_matrix)
   );

   mi4_queue #(.DW(MW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_matrix),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (back_matrix)
   );

   mi4_back #(.W(ELEMENT_WIDTH), .F(FRACTION_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_matrix     (back_matrix),
      .q_pop        (q_pop),
      .out_valid    (rsp_ch.valid),
      .out_ready    (rsp_ch.ready),
      .out_value    (rsp_ch.value),
      .out_position (rsp_ch.position),
      .out_singular (rsp_ch.singular),
      .out_clipped  (rsp_ch.clipped),
      .out_last     (rsp_ch.last)
   );
endmodule

// ----- sv/mi4_front.sv -----
module mi4_front #(
   parameter int W = mi4_pkg::ELEMENT_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [W-1:0]    in_element,
   output logic            in_ready,
   input  logic            q_full,
   output logic            q_push,
   output logic [16*W-1:0] q_matrix
);
   logic [W-1:0] asm_ff [15];
   logic [3:0]   count_ff, count_in;
   logic         xfer;

   // only the closing element needs room in the queue
   assign in_ready = !(count_ff == 4'd15 && q_full);
   assign xfer     = in_valid && in_ready;
   assign q_push   = xfer && (count_ff == 4'd15);
   assign count_in = xfer ? count_ff + 4'd1 : count_ff;

   always_comb begin
      q_matrix[16*W-1 -: W] = in_element;
      for (int i = 0; i < 15; i++) begin
         q_matrix[i*W +: W] = asm_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
      end
      if (xfer && count_ff != 4'd15) begin
         asm_ff[count_ff] <= in_element;
      end
   end
endmodule

// ----- sv/mi4_queue.sv -----
module mi4_queue #(
   parameter int DW = 16 * mi4_pkg::ELEMENT_WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   output logic          full,
   input  logic          pop,
   output logic          valid,
   output logic [DW-1:0] pop_data
);
   logic [DW-1:0] slot_ff [2];
   logic          wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign valid    = (cnt_ff != 2'd0);
   assign pop_data = slot_ff[rp_ff];
   assign wp_in    = push ? !wp_ff : wp_ff;
   assign rp_in    = pop ? !rp_ff : rp_ff;
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end
endmodule

// ----- sv/mi4_back.sv -----
module mi4_back #(
   parameter int W = mi4_pkg::ELEMENT_WIDTH,
   parameter int F = mi4_pkg::FRACTION_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  logic [16*W-1:0]     q_matrix,
   output logic                q_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic signed [W-1:0] out_value,
   output logic [3:0]          out_position,
   output logic                out_singular,
   output logic                out_clipped,
   output logic                out_last
);
   localparam int PW  = 4 * W + 6;
   localparam int NW  = 3 * W + 2 * F;
   localparam int DW  = 4 * W + 3;
   localparam int MCW = $clog2(W);
   localparam int DCW = $clog2(NW);

   typedef enum logic [12:0] {
      S_IDLE  = 13'h0001,
      S_TB    = 13'h0002,
      S_TA    = 13'h0004,
      S_MUL   = 13'h0008,
      S_MEND  = 13'h0010,
      S_CST   = 13'h0020,
      S_DADDR = 13'h0040,
      S_DLOAD = 13'h0080,
      S_QADDR = 13'h0100,
      S_QLOAD = 13'h0200,
      S_DIV   = 13'h0400,
      S_SAT   = 13'h0800,
      S_SEND  = 13'h1000
   } state_type;

   typedef enum logic [2:0] {
      MODE_T1  = 3'b001,
      MODE_T2  = 3'b010,
      MODE_DET = 3'b100
   } mode_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;

   logic [W-1:0]   mat_ff [16];
   logic [W-1:0]   mat_rd;
   logic [3:0]     elem_idx;
   logic [3:0]     cr_ff, cr_in, k_ff, k_in;
   logic [2:0]     term_ff, term_in;
   logic [1:0]     dc_ff, dc_in, erow;
   logic signed [PW-1:0] b_ff, b_in, bsh_ff, bsh_in, prod_ff, prod_in;
   logic signed [PW-1:0] acc_ff, acc_in, det_ff, det_in, mres, rd_abs, det_abs;
   logic [W-1:0]   amag_ff, amag_in;
   logic           aneg_ff, aneg_in;
   logic [MCW-1:0] mcnt_ff, mcnt_in;
   logic [NW-1:0]  num_ff, num_in, quo_ff, quo_in, lim;
   logic [DW-1:0]  rem_ff, rem_in, rem_sh, dmag;
   logic           qneg_ff, qneg_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic signed [W-1:0] val_ff, val_in;
   logic [3:0]     pos_ff, pos_in;
   logic           sing_ff, sing_in, clip_ff, clip_in, last_ff, last_in;

   logic signed [PW-1:0] cof_mem [16];
   logic signed [PW-1:0] rd_ff;
   logic [3:0]     rd_addr;
   logic           mem_we;
   logic signed [PW-1:0] mem_wd;

   // which 3x3 row feeds the current fetch
   always_comb begin
      unique case (1'b1)
         state_ff == S_TB:   erow = 2'd1;
         mode_ff == MODE_T2: erow = 2'd2;
         default:            erow = 2'd0;
      endcase
      if (mode_ff == MODE_DET && state_ff == S_TA) begin
         elem_idx = {2'b00, dc_ff};
      end else begin
         elem_idx = {mi4_pkg::skip_idx(cr_ff[3:2], erow),
                     mi4_pkg::skip_idx(cr_ff[1:0], mi4_pkg::perm_col(term_ff, erow))};
      end
   end
   assign mat_rd = mat_ff[elem_idx];

   assign mres    = aneg_ff ? -prod_ff : prod_ff;
   assign rd_abs  = rd_ff[PW-1] ? -rd_ff : rd_ff;
   assign det_abs = det_ff[PW-1] ? -det_ff : det_ff;
   assign dmag    = det_abs[DW-1:0];
   assign rem_sh  = {rem_ff[DW-2:0], num_ff[NW-1]};
   assign lim     = NW'(1) << (W - 1);
   assign rd_addr = (state_ff == S_QADDR) ? {k_ff[1:0], k_ff[3:2]} : {2'b00, dc_ff};
   assign mem_we  = (state_ff == S_CST);
   // cofactor sign follows the parity of row plus column
   assign mem_wd  = (cr_ff[2] ^ cr_ff[0]) ? -acc_ff : acc_ff;
   assign q_pop   = (state_ff == S_IDLE) && q_valid;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cr_in    = cr_ff;
      k_in     = k_ff;
      term_in  = term_ff;
      dc_in    = dc_ff;
      b_in     = b_ff;
      bsh_in   = bsh_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      det_in   = det_ff;
      amag_in  = amag_ff;
      aneg_in  = aneg_ff;
      mcnt_in  = mcnt_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      qneg_in  = qneg_ff;
      dcnt_in  = dcnt_ff;
      val_in   = val_ff;
      pos_in   = pos_ff;
      sing_in  = sing_ff;
      clip_in  = clip_ff;
      last_in  = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cr_in    = 4'd0;
               term_in  = 3'd0;
               acc_in   = '0;
               mode_in  = MODE_T1;
               state_in = S_TB;
            end
         end
         S_TB: begin
            b_in     = PW'($signed(mat_rd));
            state_in = S_TA;
         end
         S_TA: begin
            aneg_in  = mat_rd[W-1];
            amag_in  = mat_rd[W-1] ? -mat_rd : mat_rd;
            bsh_in   = b_ff;
            prod_in  = '0;
            mcnt_in  = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            if (amag_ff[0]) begin
               prod_in = prod_ff + bsh_ff;
            end
            bsh_in  = bsh_ff <<< 1;
            amag_in = amag_ff >> 1;
            mcnt_in = mcnt_ff + MCW'(1);
            if (mcnt_ff == MCW'(W - 1)) begin
               state_in = S_MEND;
            end
         end
         S_MEND: begin
            unique case (mode_ff)
               MODE_T1: begin
                  b_in     = mres;
                  mode_in  = MODE_T2;
                  state_in = S_TA;
               end
               MODE_T2: begin
                  acc_in  = mi4_pkg::term_neg(term_ff) ? acc_ff - mres : acc_ff + mres;
                  mode_in = MODE_T1;
                  if (term_ff == 3'd5) begin
                     state_in = S_CST;
                  end else begin
                     term_in  = term_ff + 3'd1;
                     state_in = S_TB;
                  end
               end
               MODE_DET: begin
                  det_in = det_ff + mres;
                  if (dc_ff == 2'd3) begin
                     k_in     = 4'd0;
                     state_in = S_QADDR;
                  end else begin
                     dc_in    = dc_ff + 2'd1;
                     state_in = S_DADDR;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_CST: begin
            if (cr_ff == 4'd15) begin
               dc_in    = 2'd0;
               det_in   = '0;
               state_in = S_DADDR;
            end else begin
               cr_in    = cr_ff + 4'd1;
               term_in  = 3'd0;
               acc_in   = '0;
               state_in = S_TB;
            end
         end
         S_DADDR: state_in = S_DLOAD;
         S_DLOAD: begin
            b_in     = rd_ff;
            mode_in  = MODE_DET;
            state_in = S_TA;
         end
         S_QADDR: state_in = S_QLOAD;
         S_QLOAD: begin
            pos_in  = k_ff;
            last_in = (k_ff == 4'd15);
            if (det_ff == '0) begin
               val_in   = '0;
               sing_in  = 1'b1;
               clip_in  = 1'b0;
               state_in = S_SEND;
            end else begin
               sing_in  = 1'b0;
               qneg_in  = rd_ff[PW-1] ^ det_ff[PW-1];
               num_in   = NW'(rd_abs[3*W-1:0]) << (2 * F);
               rem_in   = '0;
               quo_in   = '0;
               dcnt_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            num_in  = num_ff << 1;
            dcnt_in = dcnt_ff + DCW'(1);
            if (rem_sh >= dmag) begin
               rem_in = rem_sh - dmag;
               quo_in = {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[NW-2:0], 1'b0};
            end
            if (dcnt_ff == DCW'(NW - 1)) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            if (qneg_ff) begin
               clip_in = (quo_ff > lim);
               val_in  = clip_in ? -lim[W-1:0] : -quo_ff[W-1:0];
            end else begin
               clip_in = (quo_ff > lim - NW'(1));
               val_in  = clip_in ? (lim[W-1:0] - W'(1)) : quo_ff[W-1:0];
            end
            state_in = S_SEND;
         end
         S_SEND: begin
            if (out_ready) begin
               if (k_ff == 4'd15) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = S_QADDR;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_T1;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
      if (q_pop) begin
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= q_matrix[i*W +: W];
         end
      end
      cr_ff   <= cr_in;
      k_ff    <= k_in;
      term_ff <= term_in;
      dc_ff   <= dc_in;
      b_ff    <= b_in;
      bsh_ff  <= bsh_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      det_ff  <= det_in;
      amag_ff <= amag_in;
      aneg_ff <= aneg_in;
      mcnt_ff <= mcnt_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      qneg_ff <= qneg_in;
      dcnt_ff <= dcnt_in;
      val_ff  <= val_in;
      pos_ff  <= pos_in;
      sing_ff <= sing_in;
      clip_ff <= clip_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cof_mem[cr_ff] <= mem_wd;
      end
      rd_ff <= cof_mem[rd_addr];
   end

   assign out_valid    = (state_ff == S_SEND);
   assign out_value    = val_ff;
   assign out_position = pos_ff;
   assign out_singular = sing_ff;
   assign out_clipped  = clip_ff;
   assign out_last     = last_ff;
endmodule
